// ----- hdl/sdet_pkg.sv -----
// ----------------------------------------------------------------------------
// sdet_pkg
// Shared types, constants and the kernel table of the directional edge
// detector.
// ----------------------------------------------------------------------------
package sdet_pkg;

  // geometry and field widths
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int ROW_W         = 12;
  localparam int COL_W         = 12;  // holds any column up to 4096 wide lines
  localparam int OUT_COL_W     = 10;
  localparam int DIM_W         = 13;  // holds any effective width up to 4096
  localparam int SUM_W         = 12;  // gradient range is -1020..1020

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // result pixel values
  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  // kernel direction codes
  localparam logic [1:0] KDIR_DIAG_RIGHT = 2'd0;
  localparam logic [1:0] KDIR_DIAG_LEFT  = 2'd1;
  localparam logic [1:0] KDIR_VERTICAL   = 2'd2;
  localparam logic [1:0] KDIR_HORIZONTAL = 2'd3;

  // kernel weights, rows top to bottom, columns left to right
  localparam logic signed [2:0] KERNEL_TAB [4][9] = '{
    '{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2},
    '{ 3'sd0, -3'sd1, -3'sd2,  3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd1,  3'sd0},
    '{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
    '{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1}
  };

  // one classified pixel waiting for the back end
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0]        pix;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    border;
    logic                    interior;
    logic                    frame_end;
  } sdet_item_t;

  // one result from the back end
  typedef struct packed {
    logic                 valid;
    logic [PIX_W-1:0]     edge_pix;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
    logic                 done;
  } sdet_result_t;

  // weighted sum of a 3x3 window, pixel i at bits i*8 in row-major order
  function automatic logic signed [SUM_W-1:0] kernel_sum(
    input logic [1:0]         dir,
    input logic [9*PIX_W-1:0] win
  );
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] pval;
    logic signed [SUM_W-1:0] wgt;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      pval = $signed({{(SUM_W-PIX_W){1'b0}}, win[i*PIX_W +: PIX_W]});
      wgt  = SUM_W'(KERNEL_TAB[dir][i]);
      acc  = acc + SUM_W'(pval * wgt);
    end
    return acc;
  endfunction

endpackage

// ----- hdl/sdet_front.sv -----
// ----------------------------------------------------------------------------
// sdet_front
// Pixel intake: row/column counters, line buffer memory, column window and
// kernel sum. Classified pixels go to the queue.
// ----------------------------------------------------------------------------
module sdet_front import sdet_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pix,
  input  logic [DIM_W-1:0] width_last,
  input  logic [ROW_W-1:0] height_last,
  input  logic [1:0]       kernel_dir,
  input  logic             q_ready,
  output logic             q_push,
  output sdet_item_t       q_item
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  // intake counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             row_end, frame_end, border, interior;

  // pipeline stage holding the pixel while its line data is read
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_border_r, s1_interior_r, s1_frame_end_r;
  logic             s1_fire;

  // line buffers, older row in the upper byte
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd_r;
  logic [PIX_W-1:0]   top_pix, mid_pix;

  // column window, two previous columns of three rows
  logic [PIX_W-1:0]   win_r [6];
  logic [9*PIX_W-1:0] win;

  assign accept   = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && (q_ready || !(s1_border_r || s1_interior_r));
  assign in_ready = !s1_valid_r || s1_fire;

  // classify the arriving pixel
  always_comb begin
    row_end   = DIM_W'(col_r) >= width_last;
    frame_end = row_end && (row_r >= height_last);
    border    = (row_r == '0) || (col_r == '0) || (row_r >= height_last) || row_end;
    interior  = (row_r >= ROW_W'(2)) && (DIM_W'(col_r) >= DIM_W'(2));
  end

  // counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r       <= in_pix;
      s1_row_r       <= row_r;
      s1_col_r       <= col_r;
      s1_border_r    <= border;
      s1_interior_r  <= interior;
      s1_frame_end_r <= frame_end;
    end
  end

  // line buffer: read on accept, write back when the pixel leaves the stage
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_col_r] <= {mid_pix, s1_pix_r};
    end
  end

  assign top_pix = line_rd_r[2*PIX_W-1:PIX_W];
  assign mid_pix = line_rd_r[PIX_W-1:0];

  // 3x3 window in row-major order
  assign win = {s1_pix_r, win_r[5], win_r[2],
                mid_pix,  win_r[4], win_r[1],
                top_pix,  win_r[3], win_r[0]};

  // column window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_pix;
      win_r[4] <= mid_pix;
      win_r[5] <= s1_pix_r;
    end
  end

  // queue entry, pixels with no result are dropped here
  assign q_push = s1_fire && (s1_border_r || s1_interior_r);

  always_comb begin
    q_item.sum       = kernel_sum(kernel_dir, win);
    q_item.pix       = s1_pix_r;
    q_item.row       = s1_row_r;
    q_item.col       = COL_W'(s1_col_r);
    q_item.border    = s1_border_r;
    q_item.interior  = s1_interior_r;
    q_item.frame_end = s1_frame_end_r;
  end

endmodule

// ----- hdl/sdet_queue.sv -----
// ----------------------------------------------------------------------------
// sdet_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module sdet_queue import sdet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sdet_item_t push_item,
  output logic       not_full,
  input  logic       pop,
  output logic       not_empty,
  output sdet_item_t head
);

  sdet_item_t        entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign not_full  = count_r != (QPTR_W+1)'(QDEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- hdl/sdet_back.sv -----
// ----------------------------------------------------------------------------
// sdet_back
// Result stage: thresholds the gradient and the border pixel and sends up to
// two results per queue entry through the output register.
// ----------------------------------------------------------------------------
module sdet_back import sdet_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  sdet_item_t       q_head,
  output logic             q_pop,
  input  logic [9:0]       edge_thr,
  input  logic [PIX_W-1:0] border_thr,
  input  logic             out_ready,
  output sdet_result_t     out_res
);

  logic                    phase_r;       // interior result of the head is sent
  sdet_result_t            res_r;
  logic                    load, emit, send_interior;
  logic signed [SUM_W-1:0] mag;
  logic                    edge_hit, border_hit;

  assign load          = !res_r.valid || out_ready;
  assign emit          = q_valid && load;
  assign send_interior = q_head.interior && !phase_r;
  assign q_pop         = emit && !(send_interior && q_head.border);

  // gradient magnitude and the two threshold tests
  always_comb begin
    mag        = q_head.sum[SUM_W-1] ? -q_head.sum : q_head.sum;
    edge_hit   = $unsigned(mag) > SUM_W'(edge_thr);
    border_hit = q_head.pix >= border_thr;
  end

  // sequencing of interior then border result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (emit) begin
      phase_r <= send_interior && q_head.border;
    end
  end

  // output register, only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (emit) begin
      res_r.valid <= 1'b1;
    end else if (out_ready) begin
      res_r.valid <= 1'b0;
    end
    if (emit) begin
      if (send_interior) begin
        res_r.edge_pix <= edge_hit ? EDGE_ON : EDGE_OFF;
        res_r.row      <= q_head.row - ROW_W'(1);
        res_r.col      <= OUT_COL_W'(q_head.col - COL_W'(1));
        res_r.last     <= !q_head.border;
        res_r.done     <= 1'b0;
      end else begin
        res_r.edge_pix <= border_hit ? EDGE_ON : EDGE_OFF;
        res_r.row      <= q_head.row;
        res_r.col      <= OUT_COL_W'(q_head.col);
        res_r.last     <= 1'b1;
        res_r.done     <= q_head.frame_end;
      end
    end
  end

  assign out_res = res_r;

endmodule

// ----- hdl/sobel_direction_edge_threshold.sv -----
// ----------------------------------------------------------------------------
// sobel_direction_edge_threshold
// Streaming directional 3x3 edge detector with binary output.
// ----------------------------------------------------------------------------
// Takes one gray pixel per clock in raster order while the queue has room: the
// line buffer memory has one read port (used when a pixel is accepted) and one
// write port (used when it leaves the intake stage), so the intake never stalls
// on its own. A pixel on the frame border is answered with 255 when it is at or
// above border_threshold, else 0; an interior pixel is answered when the pixel
// below and right of it arrives, 255 when the absolute kernel sum exceeds
// edge_threshold. A pixel two or more rows down that sits in the last column,
// or in the last row from the third column on, raises two results, sent one
// after the other; a four-entry queue between intake and result stage absorbs
// the one at each row end and short output stalls, while along the last row of
// a frame the output sets the pace and the intake slows down. The first result
// a pixel raises passes through the intake stage register, the queue and the
// output register. Line buffer contents are not cleared after reset; only the
// first two rows of a frame write them before they matter, so no clearing pass
// is needed. The user must write configuration only while no pixel is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sobel_direction_edge_threshold import sdet_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] gray_pixel
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] edge_pixel, [19:8] pixel_row,
                                  // [29:20] pixel_column, [31:30] zero
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // frame_done
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  // register indexes
  localparam logic [2:0] REG_FRAME_WIDTH      = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_KERNEL_DIRECTION = 3'd2;
  localparam logic [2:0] REG_EDGE_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_BORDER_THRESHOLD = 3'd4;

  logic [10:0]      frame_width_r;
  logic [11:0]      frame_height_r;
  logic [1:0]       kernel_dir_r;
  logic [9:0]       edge_thr_r;
  logic [PIX_W-1:0] border_thr_r;

  logic [DIM_W-1:0] width_eff, width_last;
  logic [ROW_W-1:0] height_eff, height_last;

  logic             q_push, q_pop, q_not_full, q_not_empty;
  sdet_item_t       q_in, q_head;
  sdet_result_t     res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 12'd480;
      kernel_dir_r   <= KDIR_VERTICAL;
      edge_thr_r     <= 10'd100;
      border_thr_r   <= 8'd30;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:      frame_width_r  <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT:     frame_height_r <= cfg_wdata[11:0];
        REG_KERNEL_DIRECTION: kernel_dir_r   <= cfg_wdata[1:0];
        REG_EDGE_THRESHOLD:   edge_thr_r     <= cfg_wdata[9:0];
        REG_BORDER_THRESHOLD: border_thr_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // effective geometry, width clamped to at least 3 and to the line buffer size, height to at least 3
  always_comb begin
    if (frame_width_r < 11'd3) begin
      width_eff = DIM_W'(3);
    end else if (DIM_W'(frame_width_r) > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = DIM_W'(frame_width_r);
    end
    height_eff  = (frame_height_r < 12'd3) ? 12'd3 : frame_height_r;
    width_last  = width_eff - DIM_W'(1);
    height_last = height_eff - ROW_W'(1);
  end

  sdet_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_pix      (in_tdata),
    .width_last  (width_last),
    .height_last (height_last),
    .kernel_dir  (kernel_dir_r),
    .q_ready     (q_not_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  sdet_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sdet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .edge_thr   (edge_thr_r),
    .border_thr (border_thr_r),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // output packing
  assign out_tvalid = res.valid;
  assign out_tdata  = {2'b00, res.col, res.row, res.edge_pix};
  assign out_tlast  = res.last;
  assign out_tuser  = res.done;

  // results are binary pixels
  a_edge_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == EDGE_ON || out_tdata[7:0] == EDGE_OFF))
    else $error("edge pixel is neither 0 nor 255");

  // end of frame is always the last result of its pixel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame done without last of run");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
